// ===== rtl/half_vector_to_unit_quaternion_core_macros.svh =====
// assertion macros for the half vector to unit quaternion core
`ifndef HALF_VECTOR_TO_UNIT_QUATERNION_CORE_MACROS_SVH
`define HALF_VECTOR_TO_UNIT_QUATERNION_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define HVQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HVQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hvq_pkg.sv =====
// shared types, constants and widths of the half vector to unit quaternion core
`timescale 1ns / 1ps
`default_nettype none

package hvq_pkg;

    localparam int FRAC_BITS_DEF = 15;

    localparam int HALF_W  = 16;
    localparam int EXP_W   = 5;
    localparam int MAN_W   = 10;
    localparam int MAG_W   = 40;   // (2^11 - 1) << 29 at most
    localparam int NM_W    = 25;   // magnitude of at most 2^24
    localparam int MS_W    = 30;   // renormalized magnitude
    localparam int BL_W    = 6;
    localparam int SHA_W   = 5;
    localparam int ONE_SH  = 24;   // magnitudes are in units of 2^-24
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int ROOT_STAGES = 32;
    localparam int OUT_W   = 16;
    localparam int W_W     = 15;
    localparam int Q_DEPTH = 4;

    localparam logic [EXP_W-1:0] EXP_SPECIAL = 5'h1F;
    localparam logic [EXP_W-1:0] EXP_ZERO    = 5'h00;

    typedef struct packed {
        logic [HALF_W-1:0] vec_x_half;
        logic [HALF_W-1:0] vec_y_half;
        logic [HALF_W-1:0] vec_z_half;
    } t_in_beat;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
        logic [W_W-1:0]          quat_w;
        logic                    was_renormalized;
        logic                    nonfinite_input;
    } t_out_beat;

    // decoded item as it sits in the queue
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  nonfinite;
        logic                  big;
        logic                  shr;
        logic [SHA_W-1:0]      sha;
    } t_cls;

    // per-item data that rides along the back pipeline
    typedef struct packed {
        logic [2:0]            neg;
        logic                  nonfinite;
        logic                  renorm;
        logic [2:0][W_W-1:0]   nq;
        logic [2:0][MS_W-1:0]  ms;
        logic [W_W-1:0]        w;
    } t_side;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

endpackage

`default_nettype wire

// ===== rtl/hvq_front.sv =====
// front end: takes input beats, decodes the three halves and classifies them
`timescale 1ns / 1ps
`default_nettype none

module hvq_front
    import hvq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output logic     o_stall,
    input  t_q_sts   i_q_sts,
    output logic     o_push,
    output t_cls     o_cls
);

    logic               adv;
    logic               r_valid;
    t_cls               r_cls;
    t_cls               n_cls;
    logic [2:0][HALF_W-1:0] h;

    function automatic logic [BL_W-1:0] man_len(input logic [MAN_W-1:0] man);
        logic [BL_W-1:0] n;
        n = '0;
        for (int b = 0; b < MAN_W; b++) begin
            if (man[b]) begin
                n = BL_W'(b + 1);
            end
        end
        return n;
    endfunction

    assign adv     = !r_valid || !i_q_sts.full;
    assign o_stall = !adv;
    assign o_push  = r_valid && !i_q_sts.full;
    assign o_cls   = r_cls;
    assign h       = {i_beat.vec_z_half, i_beat.vec_y_half, i_beat.vec_x_half};

    always_comb begin
        logic [EXP_W-1:0] ex;
        logic [MAN_W-1:0] man;
        logic [BL_W-1:0]  bl;
        logic [BL_W-1:0]  bl_max;
        n_cls  = '0;
        bl_max = '0;
        for (int c = 0; c < 3; c++) begin
            ex  = h[c][HALF_W-2 -: EXP_W];
            man = h[c][MAN_W-1:0];
            n_cls.neg[c] = h[c][HALF_W-1];
            if (ex == EXP_SPECIAL) begin
                n_cls.nonfinite = 1'b1;
                n_cls.mag[c]    = '0;
                bl              = '0;
            end else if (ex == EXP_ZERO) begin
                n_cls.mag[c] = MAG_W'(man);
                bl           = man_len(man);
            end else begin
                n_cls.mag[c] = MAG_W'({1'b1, man}) << (ex - 5'd1);
                bl           = BL_W'(ex) + BL_W'(MAN_W);
            end
            if (n_cls.mag[c] > (MAG_W'(1) << ONE_SH)) begin
                n_cls.big = 1'b1;
            end
            if (bl > bl_max) begin
                bl_max = bl;
            end
        end
        // common shift that brings the largest magnitude to exactly 30 bits
        n_cls.shr = bl_max > BL_W'(MS_W);
        n_cls.sha = n_cls.shr ? SHA_W'(bl_max - BL_W'(MS_W)) : SHA_W'(BL_W'(MS_W) - bl_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_cls <= n_cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hvq_queue.sv =====
// short queue between the classifying front and the arithmetic back
`timescale 1ns / 1ps
`default_nettype none

module hvq_queue
    import hvq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_q_ctl i_ctl,
    input  t_cls   i_data,
    output t_q_sts o_sts,
    output t_cls   o_data
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cls             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_sts.full  = r_cnt == CNT_W'(Q_DEPTH);
    assign o_sts.empty = r_cnt == '0;
    assign o_data      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_ctl.pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            unique case ({i_ctl.push, i_ctl.pop})
                2'b10: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                2'b01: begin
                    r_cnt <= r_cnt - 1'b1;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hvq_back.sv =====
// back end: squares, root, divide and output register, one beat per cycle unless the output stalls
`timescale 1ns / 1ps
`default_nettype none

module hvq_back
    import hvq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_sts    i_q_sts,
    input  t_cls      i_cls,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_beat o_beat,
    input  logic      i_stall
);

    localparam int QW     = FRAC_BITS + 1;
    localparam int NW     = MS_W + FRAC_BITS + 1;
    localparam int DW     = ROOT_W + QW;
    localparam int NQ_W   = NM_W + FRAC_BITS + 1;
    localparam int SQ_W   = 2 * NM_W;
    localparam int SQM_W  = 2 * MS_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int SUMM_W = SQM_W + 2;
    localparam int D_W    = 2 * ONE_SH + 1;
    localparam int RW1    = ROOT_W + 1;
    localparam int W_SH   = 2 * FRAC_BITS + 2 - 2 * ONE_SH;
    localparam int PIPE_N = 3 + ROOT_STAGES + 1 + QW + 2;
    localparam logic [W_W-1:0] QMAX =
        (FRAC_BITS >= W_W) ? {W_W{1'b1}} : W_W'((1 << FRAC_BITS) - 1);
    localparam logic [SUM_W-1:0] ONE_SQ = SUM_W'(1) << (2 * ONE_SH);

    logic              adv;
    logic [PIPE_N-1:0] r_vld;

    assign adv     = !r_vld[PIPE_N-1] || !i_stall;
    assign o_pop   = adv && !i_q_sts.empty;
    assign o_valid = r_vld[PIPE_N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_N-2:0], o_pop};
        end
    end

    // stage 1: direct rounding for the in-range case, renormalizing shift
    t_side                  n1_side;
    logic [2:0][NM_W-1:0]   n1_mag;

    always_comb begin
        logic [NQ_W-1:0] nq_full;
        n1_side           = '0;
        n1_side.neg       = i_cls.neg;
        n1_side.nonfinite = i_cls.nonfinite;
        for (int c = 0; c < 3; c++) begin
            n1_mag[c] = i_cls.mag[c][NM_W-1:0];
            nq_full = ((NQ_W'(n1_mag[c]) << FRAC_BITS) + (NQ_W'(1) << (ONE_SH - 1)))
                      >> ONE_SH;
            n1_side.nq[c] = (nq_full > NQ_W'(QMAX)) ? QMAX : W_W'(nq_full);
            n1_side.ms[c] = i_cls.shr ? MS_W'(i_cls.mag[c] >> i_cls.sha)
                                      : MS_W'(i_cls.mag[c] << i_cls.sha);
        end
    end

    t_side                  r1_side;
    t_side                  r2_side;
    t_side                  r3_side;
    logic                   r1_big;
    logic                   r2_big;
    logic                   r3_big;
    logic [2:0][NM_W-1:0]   r1_mag;
    logic [2:0][SQ_W-1:0]   r2_sq;
    logic [2:0][SQM_W-1:0]  r2_sqm;
    logic [SUM_W-1:0]       r3_s;
    logic [SUMM_W-1:0]      r3_sm;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_side <= n1_side;
            r1_mag  <= n1_mag;
            r1_big  <= i_cls.big;
            r2_side <= r1_side;
            r2_big  <= r1_big;
            for (int c = 0; c < 3; c++) begin
                r2_sq[c]  <= r1_mag[c] * r1_mag[c];
                r2_sqm[c] <= r1_side.ms[c] * r1_side.ms[c];
            end
            r3_side <= r2_side;
            r3_big  <= r2_big;
            r3_s    <= SUM_W'(r2_sq[0]) + SUM_W'(r2_sq[1]) + SUM_W'(r2_sq[2]);
            r3_sm   <= SUMM_W'(r2_sqm[0]) + SUMM_W'(r2_sqm[1]) + SUMM_W'(r2_sqm[2]);
        end
    end

    // stage 4: pick the radicand, 1 - sum scaled for w or the renormalized sum
    logic             s4_renorm;
    logic [D_W-1:0]   s4_d;
    logic [RAD_W-1:0] s4_x;
    logic [RAD_W-1:0] s4_rad;
    t_side            s4_side;

    assign s4_renorm = r3_big || (r3_s > ONE_SQ);
    assign s4_d      = D_W'(ONE_SQ - r3_s);

    if (W_SH >= 0) begin : g_w_left
        assign s4_x = RAD_W'(s4_d) << W_SH;
    end else begin : g_w_right
        assign s4_x = RAD_W'(s4_d >> (-W_SH));
    end

    assign s4_rad = s4_renorm ? RAD_W'(r3_sm) : s4_x;

    always_comb begin
        s4_side        = r3_side;
        s4_side.renorm = s4_renorm;
    end

    // digit-by-digit square root, one result bit per stage
    logic [RAD_W-1:0] r_rv [ROOT_STAGES+1];
    logic [RAD_W-1:0] r_rr [ROOT_STAGES+1];
    t_side            r_rs [ROOT_STAGES+1];

    function automatic logic [RAD_W-1:0] root_bit(input int j);
        return RAD_W'(1) << (RAD_W - 2 - 2 * j);
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rv[0] <= s4_rad;
            r_rr[0] <= '0;
            r_rs[0] <= s4_side;
            for (int j = 0; j < ROOT_STAGES; j++) begin
                r_rs[j+1] <= r_rs[j];
                if (r_rv[j] >= r_rr[j] + root_bit(j)) begin
                    r_rv[j+1] <= r_rv[j] - (r_rr[j] + root_bit(j));
                    r_rr[j+1] <= (r_rr[j] >> 1) + root_bit(j);
                end else begin
                    r_rv[j+1] <= r_rv[j];
                    r_rr[j+1] <= r_rr[j] >> 1;
                end
            end
        end
    end

    // divider entry: w for the in-range case, rounded numerators otherwise
    logic [ROOT_W-1:0] d0_root;
    logic [RW1-1:0]    d0_wr;
    t_side             d0_side;

    assign d0_root = r_rr[ROOT_STAGES][ROOT_W-1:0];
    assign d0_wr   = ({1'b0, d0_root} + 1'b1) >> 1;

    always_comb begin
        d0_side   = r_rs[ROOT_STAGES];
        d0_side.w = (d0_wr > RW1'(QMAX)) ? QMAX : W_W'(d0_wr);
    end

    logic [2:0][NW-1:0] r_dn    [QW+1];
    logic [2:0][QW-1:0] r_dq    [QW+1];
    logic [ROOT_W-1:0]  r_droot [QW+1];
    t_side              r_ds    [QW+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_droot[0] <= d0_root;
            r_ds[0]    <= d0_side;
            for (int c = 0; c < 3; c++) begin
                r_dn[0][c] <= (NW'(d0_side.ms[c]) << FRAC_BITS) + NW'(d0_root >> 1);
                r_dq[0][c] <= '0;
            end
            // restoring division, quotient msb first
            for (int k = 0; k < QW; k++) begin
                r_droot[k+1] <= r_droot[k];
                r_ds[k+1]    <= r_ds[k];
                for (int c = 0; c < 3; c++) begin
                    if (DW'(r_dn[k][c]) >= (DW'(r_droot[k]) << (QW - 1 - k))) begin
                        r_dn[k+1][c] <= NW'(DW'(r_dn[k][c]) - (DW'(r_droot[k]) << (QW - 1 - k)));
                        r_dq[k+1][c] <= r_dq[k][c] | (QW'(1) << (QW - 1 - k));
                    end else begin
                        r_dn[k+1][c] <= r_dn[k][c];
                        r_dq[k+1][c] <= r_dq[k][c];
                    end
                end
            end
        end
    end

    // output register
    t_out_beat             n_out;
    t_out_beat             r_out;
    logic [2:0][OUT_W-1:0] qs;

    always_comb begin
        logic [W_W-1:0] mag;
        for (int c = 0; c < 3; c++) begin
            if (r_ds[QW].renorm) begin
                if (r_droot[QW] == '0) begin
                    mag = '0;
                end else begin
                    mag = (r_dq[QW][c] > QW'(QMAX)) ? QMAX : W_W'(r_dq[QW][c]);
                end
            end else begin
                mag = r_ds[QW].nq[c];
            end
            qs[c] = {1'b0, mag};
            if (r_ds[QW].neg[c]) begin
                qs[c] = -qs[c];
            end
        end
        n_out                  = '0;
        n_out.quat_x           = signed'(qs[0]);
        n_out.quat_y           = signed'(qs[1]);
        n_out.quat_z           = signed'(qs[2]);
        n_out.quat_w           = r_ds[QW].renorm ? '0 : r_ds[QW].w;
        n_out.was_renormalized = r_ds[QW].renorm;
        if (r_ds[QW].nonfinite) begin
            n_out                 = '0;
            n_out.nonfinite_input = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_beat = r_out;

endmodule

`default_nettype wire

// ===== rtl/half_vector_to_unit_quaternion_core.sv =====
// top level: half-float vector part in, unit quaternion in signed fixed point out
//
//   channel | handshake           | beat
//   --------+---------------------+-------------------------------------------
//   input   | i_valid / o_stall   | t_in_beat: x, y, z half-precision words
//   output  | o_valid / i_stall   | t_out_beat: quat x, y, z, w and two flags
//
// one beat per cycle sustained while i_stall is low; the path runs through the
// 32-step square root pipeline and the FRAC_BITS + 1 step divider
// reset is synchronous and active low and empties the pipeline and the queue
// output stall freezes the back pipeline; the front keeps taking beats until
// the four-entry queue fills
`timescale 1ns / 1ps
`default_nettype none
`include "half_vector_to_unit_quaternion_core_macros.svh"

module half_vector_to_unit_quaternion_core
    import hvq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_beat,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_beat o_beat,
    input  logic      i_stall
);

    t_q_ctl q_ctl;
    t_q_sts q_sts;
    t_cls   front_cls;
    t_cls   q_cls;
    logic   push;
    logic   pop;

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    hvq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_beat  (i_beat),
        .o_stall (o_stall),
        .i_q_sts (q_sts),
        .o_push  (push),
        .o_cls   (front_cls)
    );

    hvq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_data  (front_cls),
        .o_sts   (q_sts),
        .o_data  (q_cls)
    );

    hvq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_sts (q_sts),
        .i_cls   (q_cls),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_beat  (o_beat),
        .i_stall (i_stall)
    );

    logic out_nonf;
    logic out_renorm;
    logic out_zero;
    logic w_zero;

    assign out_nonf   = o_valid && o_beat.nonfinite_input;
    assign out_renorm = o_valid && o_beat.was_renormalized;
    assign w_zero     = o_beat.quat_w == '0;
    assign out_zero   = o_beat.quat_x == '0 && o_beat.quat_y == '0 && o_beat.quat_z == '0
                        && w_zero && !o_beat.was_renormalized;

    `HVQ_ASSERT_NOW(a_nonfinite_zero, i_clk, i_rst_n, out_nonf, out_zero, "nonfinite not zero")
    `HVQ_ASSERT_NOW(a_renorm_w_zero, i_clk, i_rst_n, out_renorm, w_zero, "renorm w not zero")
    `HVQ_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, push, !q_sts.full, "queue push while full")
    `HVQ_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, pop, !q_sts.empty, "queue pop while empty")
    `HVQ_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, push && !pop, !q_sts.empty, "empty after push")

endmodule

`default_nettype wire
